@@ rtl/jqsr_pkg.sv @@
package jqsr_pkg;

  // Default number of entries the queue can hold.
  localparam int QUEUE_DEPTH_DEF = 16;

  // Width of the fill count reported with each result.
  localparam int FILL_W = 5;

  // Operation codes carried on the input channel.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_APPEND = 2'd1,
    OP_POP    = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  // Status codes returned with each result.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH,
    S_EMIT
  } state_t;

  // One job record as it is held in the entry store.
  typedef struct packed {
    logic [15:0] job_id;
    logic [15:0] mem_need;
    logic [7:0]  device_count;
    logic [15:0] run_time;
    logic [3:0]  prio_level;
  } job_t;

  localparam int JOB_W = $bits(job_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    start;
    logic    append;
    logic    walk;
    logic    finish;
    logic    load_out;
    status_t status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic walk_done;
    logic found;
    op_t  op;
  } dp_stat_t;

endpackage

@@ rtl/jqsr_ram.sv @@
module jqsr_ram
  import jqsr_pkg::*;
#(
  parameter int WIDTH = JOB_W,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one read port with a registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/jqsr_ctrl.sv @@
module jqsr_ctrl
  import jqsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_opcode,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    accept;
  logic    out_free;
  op_t     in_op;

  assign in_op    = op_t'(in_opcode);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Next state and the status that the result will carry.
  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_INSERT, OP_APPEND: begin
              if (stat.full) begin
                state_nxt = S_EMIT;
                st_nxt    = ST_FULL;
              end else if (in_op == OP_APPEND) begin
                state_nxt = S_EMIT;
                st_nxt    = ST_OK;
              end else begin
                state_nxt = S_WALK;
              end
            end
            default: begin
              if (stat.empty) begin
                state_nxt = S_EMIT;
                st_nxt    = ST_EMPTY;
              end else begin
                state_nxt = S_WALK;
              end
            end
          endcase
        end
      end
      S_WALK: begin
        if (stat.walk_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        state_nxt = S_EMIT;
        st_nxt    = (stat.op == OP_INSERT || stat.found) ? ST_OK : ST_MISSING;
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands to the datapath and the result valid flag.
  always_comb begin
    cmd           = '0;
    cmd.status    = st_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        cmd.start  = accept;
        cmd.append = accept && (in_op == OP_APPEND) && !stat.full;
      end
      S_WALK:   cmd.walk   = 1'b1;
      S_FINISH: cmd.finish = 1'b1;
      S_EMIT: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      st_r        <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ rtl/jqsr_dp.sv @@
module jqsr_dp
  import jqsr_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        in_opcode,
  input  logic [15:0]       in_job_id,
  input  logic [15:0]       in_mem_need,
  input  logic [7:0]        in_device_count,
  input  logic [15:0]       in_run_time,
  input  logic [3:0]        in_prio_level,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  output logic [1:0]        out_status,
  output logic [15:0]       out_job_id,
  output logic [15:0]       out_mem_need,
  output logic [7:0]        out_device_count,
  output logic [15:0]       out_run_time,
  output logic [3:0]        out_prio_level,
  output logic [FILL_W-1:0] out_fill_count
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Control state of the walk and the fill count.
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] rd_i_r, rd_i_nxt;
  logic          dvld_r, dvld_nxt;
  logic          found_r, found_nxt;

  // Payload held across one operation.
  op_t  op_r, op_nxt;
  job_t new_r, new_nxt;
  job_t carry_r, carry_nxt;
  job_t taken_r, taken_nxt;

  // Result register.
  status_t           ost_r, ost_nxt;
  job_t              ojob_r, ojob_nxt;
  logic [FILL_W-1:0] ofill_r, ofill_nxt;

  // Entry store port signals.
  logic          we;
  logic [AW-1:0] waddr;
  job_t          wdata;
  job_t          rdata;
  logic [CW-1:0] d_idx;
  logic [CW-1:0] d_prev;
  job_t          in_job;

  assign in_job = '{job_id: in_job_id, mem_need: in_mem_need,
                    device_count: in_device_count, run_time: in_run_time,
                    prio_level: in_prio_level};

  // Index of the entry whose read data arrives this cycle, and the one before.
  assign d_idx  = rd_i_r - CW'(1);
  assign d_prev = rd_i_r - CW'(2);

  jqsr_ram #(
    .WIDTH(JOB_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(rd_i_r[AW-1:0]),
    .rdata(rdata)
  );

  // Walk over the store: one read issued and one entry processed per cycle.
  always_comb begin
    cnt_nxt   = cnt_r;
    rd_i_nxt  = rd_i_r;
    dvld_nxt  = dvld_r;
    found_nxt = found_r;
    op_nxt    = op_r;
    new_nxt   = new_r;
    carry_nxt = carry_r;
    taken_nxt = taken_r;
    ost_nxt   = ost_r;
    ojob_nxt  = ojob_r;
    ofill_nxt = ofill_r;
    we        = 1'b0;
    waddr     = cnt_r[AW-1:0];
    wdata     = new_r;

    if (cmd.start) begin
      op_nxt    = op_t'(in_opcode);
      new_nxt   = in_job;
      found_nxt = 1'b0;
      taken_nxt = '0;
      rd_i_nxt  = '0;
      dvld_nxt  = 1'b0;
    end

    // Append writes straight at the tail.
    if (cmd.append) begin
      we      = 1'b1;
      waddr   = cnt_r[AW-1:0];
      wdata   = in_job;
      cnt_nxt = cnt_r + CW'(1);
    end

    if (cmd.walk) begin
      if (rd_i_r < cnt_r) begin
        rd_i_nxt = rd_i_r + CW'(1);
        dvld_nxt = 1'b1;
      end else begin
        dvld_nxt = 1'b0;
      end
      if (dvld_r) begin
        if (op_r == OP_INSERT) begin
          // Past the insert point every entry moves up by one.
          if (found_r) begin
            we        = 1'b1;
            waddr     = d_idx[AW-1:0];
            wdata     = carry_r;
            carry_nxt = rdata;
          end else if (rdata.run_time > new_r.run_time) begin
            found_nxt = 1'b1;
            we        = 1'b1;
            waddr     = d_idx[AW-1:0];
            wdata     = new_r;
            carry_nxt = rdata;
          end
        end else begin
          // Past the removed entry every entry moves down by one.
          if (found_r) begin
            we    = 1'b1;
            waddr = d_prev[AW-1:0];
            wdata = rdata;
          end else if (op_r == OP_POP || rdata.job_id == new_r.job_id) begin
            found_nxt = 1'b1;
            taken_nxt = rdata;
          end
        end
      end
    end

    // Close the operation: the last entry lands at the tail, or the count drops.
    if (cmd.finish) begin
      if (op_r == OP_INSERT) begin
        we      = 1'b1;
        waddr   = cnt_r[AW-1:0];
        wdata   = found_r ? carry_r : new_r;
        cnt_nxt = cnt_r + CW'(1);
      end else if (found_r) begin
        cnt_nxt = cnt_r - CW'(1);
      end
    end

    if (cmd.load_out) begin
      ost_nxt   = cmd.status;
      ojob_nxt  = taken_r;
      ofill_nxt = FILL_W'(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      rd_i_r  <= '0;
      dvld_r  <= 1'b0;
      found_r <= 1'b0;
      op_r    <= OP_INSERT;
    end else begin
      cnt_r   <= cnt_nxt;
      rd_i_r  <= rd_i_nxt;
      dvld_r  <= dvld_nxt;
      found_r <= found_nxt;
      op_r    <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    new_r   <= new_nxt;
    carry_r <= carry_nxt;
    taken_r <= taken_nxt;
    ost_r   <= ost_nxt;
    ojob_r  <= ojob_nxt;
    ofill_r <= ofill_nxt;
  end

  // Status toward the controller.
  always_comb begin
    stat.full      = (cnt_r == CW'(QUEUE_DEPTH));
    stat.empty     = (cnt_r == '0);
    stat.walk_done = (rd_i_r == cnt_r) && !dvld_r;
    stat.found     = found_r;
    stat.op        = op_r;
  end

  assign out_status       = ost_r;
  assign out_job_id       = ojob_r.job_id;
  assign out_mem_need     = ojob_r.mem_need;
  assign out_device_count = ojob_r.device_count;
  assign out_run_time     = ojob_r.run_time;
  assign out_prio_level   = ojob_r.prio_level;
  assign out_fill_count   = ofill_r;

endmodule

@@ rtl/job_queue_sorted_by_runtime.sv @@
// Channel  | Direction | Handshake           | Payload
// in_      | input     | in_valid, in_stall  | opcode, job_id, mem_need, device_count,
//          |           |                     | run_time, prio_level
// out_     | output    | out_valid, out_stall| status, job record, fill_count
//
// One item is in work at a time. Append and the full or empty cases register the result
// without a walk; sorted insert, pop and remove first walk the filled entries of the
// entry store once through its single read port, then close the operation and register
// the result.
// Reset (rst_n low, synchronous) empties the queue; the store itself is not cleared.
// A stalled result holds in the output register; the next input is taken as soon as
// that result is registered.
module job_queue_sorted_by_runtime
  import jqsr_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_opcode,
  input  logic [15:0]       in_job_id,
  input  logic [15:0]       in_mem_need,
  input  logic [7:0]        in_device_count,
  input  logic [15:0]       in_run_time,
  input  logic [3:0]        in_prio_level,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [15:0]       out_job_id,
  output logic [15:0]       out_mem_need,
  output logic [7:0]        out_device_count,
  output logic [15:0]       out_run_time,
  output logic [3:0]        out_prio_level,
  output logic [FILL_W-1:0] out_fill_count
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  jqsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_opcode(in_opcode),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  jqsr_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_opcode       (in_opcode),
    .in_job_id       (in_job_id),
    .in_mem_need     (in_mem_need),
    .in_device_count (in_device_count),
    .in_run_time     (in_run_time),
    .in_prio_level   (in_prio_level),
    .cmd             (cmd),
    .stat            (stat),
    .out_status      (out_status),
    .out_job_id      (out_job_id),
    .out_mem_need    (out_mem_need),
    .out_device_count(out_device_count),
    .out_run_time    (out_run_time),
    .out_prio_level  (out_prio_level),
    .out_fill_count  (out_fill_count)
  );

endmodule

@@ rtl/jqsr_chk.sv @@
module jqsr_chk
  import jqsr_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [1:0]        in_opcode,
  input logic [15:0]       in_job_id,
  input logic [15:0]       in_mem_need,
  input logic [7:0]        in_device_count,
  input logic [15:0]       in_run_time,
  input logic [3:0]        in_prio_level,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        out_status,
  input logic [15:0]       out_job_id,
  input logic [15:0]       out_mem_need,
  input logic [7:0]        out_device_count,
  input logic [15:0]       out_run_time,
  input logic [3:0]        out_prio_level,
  input logic [FILL_W-1:0] out_fill_count
);

  // The queue works on one item at a time, so a transfer in blocks the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item was still in work");

  // An empty result leaves the queue empty and carries no record.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_fill_count == '0 && out_job_id == '0
      && out_run_time == '0)
    else $error("empty status with a record or a nonzero fill count");

  // Full and not-found results take nothing out.
  a_no_record: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL || out_status == ST_MISSING) |->
      out_job_id == '0 && out_mem_need == '0 && out_device_count == '0
      && out_run_time == '0 && out_prio_level == '0)
    else $error("record returned with a full or not-found status");

  // A stalled result stays offered unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_job_id)
      && $stable(out_fill_count))
    else $error("stalled result changed");

endmodule

bind job_queue_sorted_by_runtime jqsr_chk u_jqsr_chk (.*);
